// File: hw/rtl/lpfd_pkg.sv
// lpfd_pkg: shared types, codes and constants of the length-prefixed frame deframer
// no dependencies; every other file of the block refers to it by scoped names

package lpfd_pkg;

    // frame layout
    localparam int unsigned POS_W        = 17;
    localparam int unsigned PREFIX_BYTES = 4;
    localparam int unsigned HEADER_BYTES = 24;
    localparam int unsigned HDR_END      = PREFIX_BYTES + HEADER_BYTES;
    localparam int unsigned HDR_W        = 8 * HEADER_BYTES;

    // input operation codes
    typedef logic [1:0] t_op;
    localparam t_op OP_DATA  = 2'd0;
    localparam t_op OP_EOS   = 2'd1;
    localparam t_op OP_CLEAR = 2'd2;

    // result types
    typedef logic [1:0] t_rtype;
    localparam t_rtype RT_HEADER  = 2'd0;
    localparam t_rtype RT_PAYLOAD = 2'd1;
    localparam t_rtype RT_ERROR   = 2'd2;
    localparam t_rtype RT_END     = 2'd3;

    // error codes
    typedef logic [2:0] t_err;
    localparam t_err ERR_NONE     = 3'd0;
    localparam t_err ERR_SHORT    = 3'd1;
    localparam t_err ERR_TOO_BIG  = 3'd2;
    localparam t_err ERR_MAGIC    = 3'd3;
    localparam t_err ERR_RESERVED = 3'd4;
    localparam t_err ERR_KIND     = 3'd5;
    localparam t_err ERR_EOF      = 3'd6;

    // configuration register indexes
    typedef logic [1:0] t_reg_idx;
    localparam t_reg_idx REG_MAX_FRAME = 2'd0;
    localparam t_reg_idx REG_MAGIC     = 2'd1;
    localparam t_reg_idx REG_KIND_MIN  = 2'd2;
    localparam t_reg_idx REG_KIND_MAX  = 2'd3;

    localparam logic [16:0] MAX_FRAME_RESET = 17'h10000;
    localparam logic [7:0]  KIND_MAX_RESET  = 8'hFF;

    // configuration register set
    typedef struct packed {
        logic [16:0] max_frame_bytes;
        logic [31:0] magic_word;
        logic [7:0]  kind_min;
        logic [7:0]  kind_max;
    } t_cfg;

    // one result item
    typedef struct packed {
        t_rtype      result_type;
        logic [15:0] major_version;
        logic [15:0] minor_version;
        logic [7:0]  message_kind;
        logic [7:0]  frame_flags;
        logic [15:0] command_code;
        logic [63:0] request_id;
        logic [15:0] frame_status;
        logic [15:0] payload_length;
        logic [7:0]  payload_byte;
        logic        last;
        t_err        error_code;
    } t_result;

endpackage

// File: hw/rtl/lpfd_cfg_if.sv
// lpfd_cfg_if: configuration write channel of the frame deframer
// depends on lpfd_pkg for the register index type

interface lpfd_cfg_if;
    logic                valid;
    logic                ready;
    lpfd_pkg::t_reg_idx  index;
    logic [31:0]         data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/lpfd_in_if.sv
// lpfd_in_if: input stream channel of the frame deframer (op and byte)
// depends on lpfd_pkg for the op type

interface lpfd_in_if;
    logic           valid;
    logic           ready;
    lpfd_pkg::t_op  op;
    logic [7:0]     data_byte;

    modport source (output valid, output op, output data_byte, input ready);
    modport sink   (input valid, input op, input data_byte, output ready);
endinterface

// File: hw/rtl/lpfd_out_if.sv
// lpfd_out_if: result channel of the frame deframer
// depends on lpfd_pkg for the result type and error code types

interface lpfd_out_if;
    logic                valid;
    logic                ready;
    lpfd_pkg::t_rtype    result_type;
    logic [15:0]         major_version;
    logic [15:0]         minor_version;
    logic [7:0]          message_kind;
    logic [7:0]          frame_flags;
    logic [15:0]         command_code;
    logic [63:0]         request_id;
    logic [15:0]         frame_status;
    logic [15:0]         payload_length;
    logic [7:0]          payload_byte;
    logic                last;
    lpfd_pkg::t_err      error_code;

    modport source (
        output valid, output result_type, output major_version, output minor_version,
        output message_kind, output frame_flags, output command_code, output request_id,
        output frame_status, output payload_length, output payload_byte, output last,
        output error_code, input ready
    );
    modport sink (
        input valid, input result_type, input major_version, input minor_version,
        input message_kind, input frame_flags, input command_code, input request_id,
        input frame_status, input payload_length, input payload_byte, input last,
        input error_code, output ready
    );
endinterface

// File: hw/rtl/lpfd_cfg.sv
// lpfd_cfg: configuration registers of the frame deframer
// depends on lpfd_pkg for register indexes, reset values and the t_cfg struct

module lpfd_cfg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_wr_valid,
    input  lpfd_pkg::t_reg_idx  i_wr_index,
    input  logic [31:0]         i_wr_data,
    output logic                o_wr_ready,
    output lpfd_pkg::t_cfg      o_cfg
);

    lpfd_pkg::t_cfg r_cfg;

    // writes are always taken
    assign o_wr_ready = 1'b1;
    assign o_cfg      = r_cfg;

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_frame_bytes <= lpfd_pkg::MAX_FRAME_RESET;
            r_cfg.magic_word      <= '0;
            r_cfg.kind_min        <= '0;
            r_cfg.kind_max        <= lpfd_pkg::KIND_MAX_RESET;
        end else if (i_wr_valid) begin
            case (i_wr_index)
                lpfd_pkg::REG_MAX_FRAME: begin
                    r_cfg.max_frame_bytes <= i_wr_data[16:0];
                end
                lpfd_pkg::REG_MAGIC: begin
                    r_cfg.magic_word <= i_wr_data;
                end
                lpfd_pkg::REG_KIND_MIN: begin
                    r_cfg.kind_min <= i_wr_data[7:0];
                end
                lpfd_pkg::REG_KIND_MAX: begin
                    r_cfg.kind_max <= i_wr_data[7:0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// File: hw/rtl/lpfd_parse.sv
// lpfd_parse: input register, frame position tracking, header capture and checks
// depends on lpfd_pkg; feeds at most one result per item to lpfd_out_reg

module lpfd_parse #(
    parameter int unsigned MAX_FRAME_BYTES = 65536
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  lpfd_pkg::t_op       i_op,
    input  logic [7:0]          i_data_byte,
    input  lpfd_pkg::t_cfg      i_cfg,
    input  logic                i_out_free,
    output logic                o_res_load,
    output lpfd_pkg::t_result   o_res
);

    localparam int unsigned POS_W = lpfd_pkg::POS_W;
    localparam int unsigned HDR_W = lpfd_pkg::HDR_W;
    localparam logic [32:0] LIMIT_PARAM     = 33'(MAX_FRAME_BYTES);
    localparam logic [32:0] PREFIX_LEN      = 33'(lpfd_pkg::PREFIX_BYTES);
    localparam logic [31:0] HEADER_LEN      = 32'(lpfd_pkg::HEADER_BYTES);
    localparam logic [POS_W-1:0] POS_PREFIX  = POS_W'(lpfd_pkg::PREFIX_BYTES);
    localparam logic [POS_W-1:0] POS_PFX_LAST = POS_W'(lpfd_pkg::PREFIX_BYTES - 1);
    localparam logic [POS_W-1:0] POS_HDR_END = POS_W'(lpfd_pkg::HDR_END);
    localparam logic [POS_W-1:0] POS_HDR_LAST = POS_W'(lpfd_pkg::HDR_END - 1);

    // input register
    logic                 r_in_valid;
    lpfd_pkg::t_op        r_op;
    logic [7:0]           r_byte;

    // frame state
    logic [POS_W-1:0]     r_pos, n_pos;
    logic [31:0]          r_decl, n_decl;
    logic [HDR_W-1:0]     r_hdr;
    lpfd_pkg::t_err       r_err, n_err;

    logic                 adv;
    logic                 hdr_shift;
    logic                 has_res;
    lpfd_pkg::t_result    res;
    logic [HDR_W-1:0]     hdr_full;
    logic [POS_W-1:0]     pos_inc;
    logic [32:0]          total;
    logic [32:0]          total_new;
    logic [31:0]          plen;
    logic [7:0]           kind;

    assign adv        = r_in_valid && i_out_free;
    assign o_in_ready = !r_in_valid || adv;
    assign o_res_load = adv && has_res;
    assign o_res      = res;

    assign hdr_full = {r_hdr[HDR_W-9:0], r_byte};
    assign pos_inc  = r_pos + POS_W'(1);
    assign total    = PREFIX_LEN + {1'b0, r_decl};
    assign plen     = r_decl - HEADER_LEN;
    assign kind     = hdr_full[127:120];

    // one pass over the held item
    always_comb begin
        n_pos     = r_pos;
        n_decl    = r_decl;
        n_err     = r_err;
        hdr_shift = 1'b0;
        has_res   = 1'b0;
        res       = '0;
        total_new = PREFIX_LEN + {1'b0, {r_decl[23:0], r_byte}};
        if (adv) begin
            case (r_op)
                lpfd_pkg::OP_CLEAR: begin
                    n_pos  = '0;
                    n_decl = '0;
                    n_err  = lpfd_pkg::ERR_NONE;
                end
                lpfd_pkg::OP_EOS: begin
                    has_res = 1'b1;
                    if (r_err != lpfd_pkg::ERR_NONE) begin
                        res.result_type = lpfd_pkg::RT_ERROR;
                        res.error_code  = r_err;
                    end else if (r_pos != '0) begin
                        res.result_type = lpfd_pkg::RT_ERROR;
                        res.error_code  = lpfd_pkg::ERR_EOF;
                    end else begin
                        res.result_type = lpfd_pkg::RT_END;
                    end
                end
                lpfd_pkg::OP_DATA: begin
                    if (r_err != lpfd_pkg::ERR_NONE) begin
                        has_res         = 1'b1;
                        res.result_type = lpfd_pkg::RT_ERROR;
                        res.error_code  = r_err;
                    end else if (r_pos < POS_PREFIX) begin
                        // length prefix, big-endian
                        n_pos  = pos_inc;
                        n_decl = (r_pos == '0) ? {24'd0, r_byte} : {r_decl[23:0], r_byte};
                        if (r_pos == POS_PFX_LAST) begin
                            if (n_decl < HEADER_LEN) begin
                                has_res         = 1'b1;
                                n_err           = lpfd_pkg::ERR_SHORT;
                                res.result_type = lpfd_pkg::RT_ERROR;
                                res.error_code  = lpfd_pkg::ERR_SHORT;
                            end else if (total_new > {16'd0, i_cfg.max_frame_bytes} ||
                                         total_new > LIMIT_PARAM) begin
                                has_res         = 1'b1;
                                n_err           = lpfd_pkg::ERR_TOO_BIG;
                                res.result_type = lpfd_pkg::RT_ERROR;
                                res.error_code  = lpfd_pkg::ERR_TOO_BIG;
                            end
                        end
                    end else if (r_pos < POS_HDR_END) begin
                        // header capture, checked on its last byte
                        n_pos     = pos_inc;
                        hdr_shift = 1'b1;
                        if (r_pos == POS_HDR_LAST) begin
                            has_res = 1'b1;
                            if (hdr_full[191:160] != i_cfg.magic_word) begin
                                n_err           = lpfd_pkg::ERR_MAGIC;
                                res.result_type = lpfd_pkg::RT_ERROR;
                                res.error_code  = lpfd_pkg::ERR_MAGIC;
                            end else if (hdr_full[15:0] != 16'd0) begin
                                n_err           = lpfd_pkg::ERR_RESERVED;
                                res.result_type = lpfd_pkg::RT_ERROR;
                                res.error_code  = lpfd_pkg::ERR_RESERVED;
                            end else if (kind < i_cfg.kind_min || kind > i_cfg.kind_max) begin
                                n_err           = lpfd_pkg::ERR_KIND;
                                res.result_type = lpfd_pkg::RT_ERROR;
                                res.error_code  = lpfd_pkg::ERR_KIND;
                            end else begin
                                res.result_type    = lpfd_pkg::RT_HEADER;
                                res.major_version  = hdr_full[159:144];
                                res.minor_version  = hdr_full[143:128];
                                res.message_kind   = kind;
                                res.frame_flags    = hdr_full[119:112];
                                res.command_code   = hdr_full[111:96];
                                res.request_id     = hdr_full[95:32];
                                res.frame_status   = hdr_full[31:16];
                                res.payload_length = plen[15:0];
                                res.last           = (r_decl == HEADER_LEN);
                                if (r_decl == HEADER_LEN) begin
                                    n_pos = '0;
                                end
                            end
                        end
                    end else begin
                        // payload byte
                        has_res          = 1'b1;
                        res.result_type  = lpfd_pkg::RT_PAYLOAD;
                        res.payload_byte = r_byte;
                        n_pos            = pos_inc;
                        if ({16'd0, pos_inc} >= total) begin
                            res.last = 1'b1;
                            n_pos    = '0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_pos      <= '0;
            r_decl     <= '0;
            r_err      <= lpfd_pkg::ERR_NONE;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            r_pos  <= n_pos;
            r_decl <= n_decl;
            r_err  <= n_err;
        end
    end

    // item and header bytes
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_op   <= i_op;
            r_byte <= i_data_byte;
        end
        if (hdr_shift) begin
            r_hdr <= hdr_full;
        end
    end

    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err != lpfd_pkg::ERR_NONE && !(adv && r_op == lpfd_pkg::OP_CLEAR))
        |=> (r_err == $past(r_err)))
        else $error("stored error changed without a clear");

    a_hdr_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_load && o_res.result_type == lpfd_pkg::RT_HEADER) |-> (r_pos == POS_HDR_LAST))
        else $error("header result away from the last header byte");

    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_load && o_res.result_type == lpfd_pkg::RT_ERROR)
        |-> (o_res.error_code != lpfd_pkg::ERR_NONE && !o_res.last))
        else $error("error result without a code or with last set");

endmodule

// File: hw/rtl/lpfd_out_reg.sv
// lpfd_out_reg: result register between the parser and the result channel
// depends on lpfd_pkg for the t_result struct

module lpfd_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  lpfd_pkg::t_result   i_res,
    input  logic                i_ready,
    output logic                o_valid,
    output logic                o_free,
    output lpfd_pkg::t_result   o_res
);

    logic              r_valid;
    lpfd_pkg::t_result r_res;

    // free when empty or being taken this cycle
    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

// File: hw/rtl/length_prefixed_frame_deframer.sv
// Length-prefixed frame deframer: takes one stream item (data byte, end of stream or
// clear) per clock and returns at most one result per item; the item goes from the input
// register through the parse stage into the result register. Throughput is one item per
// cycle; it is set by the single parse stage that sits between the input register and the
// result register, and it drops only while the result channel is stalled. Each frame is a
// 4-byte big-endian length followed by a 24-byte header and the payload; the header comes
// out as one result after its last byte, then one result per payload byte with last on the
// final one. Errors are sticky until a clear item. Configuration writes are taken at any
// time, but should only be made while no item is in flight.
// depends on lpfd_pkg, the three channel interfaces, lpfd_cfg, lpfd_parse, lpfd_out_reg

module length_prefixed_frame_deframer #(
    parameter int unsigned MAX_FRAME_BYTES = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lpfd_cfg_if.sink    i_cfg,
    lpfd_in_if.sink     i_in,
    lpfd_out_if.source  o_out
);

    lpfd_pkg::t_cfg    cfg;
    lpfd_pkg::t_result parse_res;
    lpfd_pkg::t_result out_res;
    logic              res_load;
    logic              out_free;

    // configuration registers
    lpfd_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (i_cfg.valid),
        .i_wr_index (i_cfg.index),
        .i_wr_data  (i_cfg.data),
        .o_wr_ready (i_cfg.ready),
        .o_cfg      (cfg)
    );

    // parse stage
    lpfd_parse #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_op        (i_in.op),
        .i_data_byte (i_in.data_byte),
        .i_cfg       (cfg),
        .i_out_free  (out_free),
        .o_res_load  (res_load),
        .o_res       (parse_res)
    );

    // result register
    lpfd_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_load),
        .i_res   (parse_res),
        .i_ready (o_out.ready),
        .o_valid (o_out.valid),
        .o_free  (out_free),
        .o_res   (out_res)
    );

    // result channel fields
    assign o_out.result_type    = out_res.result_type;
    assign o_out.major_version  = out_res.major_version;
    assign o_out.minor_version  = out_res.minor_version;
    assign o_out.message_kind   = out_res.message_kind;
    assign o_out.frame_flags    = out_res.frame_flags;
    assign o_out.command_code   = out_res.command_code;
    assign o_out.request_id     = out_res.request_id;
    assign o_out.frame_status   = out_res.frame_status;
    assign o_out.payload_length = out_res.payload_length;
    assign o_out.payload_byte   = out_res.payload_byte;
    assign o_out.last           = out_res.last;
    assign o_out.error_code     = out_res.error_code;

endmodule
